>>> design/svm_pkg.sv
`timescale 1ns / 1ps
// svm_pkg: shared types, codes and constants of the stereo voice mixer
// used by svm_seq, svm_datapath and the top level; depends on nothing

package svm_pkg;

    localparam int RING_INDEX_BITS_DEF = 16;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;

    localparam logic [CFG_INDEX_W-1:0] CFG_MASTER_VOLUME  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OUTPUT_8BIT    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_OUTPUT_STEREO  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RING_SIZE_LOG2 = 3'd3;

    localparam logic [9:0]  MASTER_VOLUME_RST  = 10'd256;
    localparam logic [4:0]  RING_SIZE_LOG2_RST = 5'd14;

    localparam logic [15:0] SAT_MAX  = 16'h7fff;
    localparam logic [15:0] SAT_MIN  = 16'h8000;
    localparam logic [7:0]  OFFSET_8 = 8'h80;

    localparam int PROD_W = 42;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_VOICE_L,
        ST_VOICE_R,
        ST_VOICE_ACC,
        ST_MIX_L,
        ST_OUT_L,
        ST_OUT_R
    } t_state;

    typedef enum logic [1:0] {
        MSEL_VOICE_L,
        MSEL_VOICE_R,
        MSEL_SUM_L,
        MSEL_SUM_R
    } t_mul_sel;

    typedef struct packed {
        t_mul_sel mul_sel;
        logic     prod_en;
        logic     acc_l;
        logic     acc_r;
        logic     clear;
        logic     word_load;
        logic     word_right;
        logic     word_last;
        logic     wp_bump;
    } t_dp_ctrl;

    typedef struct packed {
        logic [15:0] sample;
        logic        is_8bit;
        logic [9:0]  lvol;
        logic [9:0]  rvol;
        logic        active;
        logic        last;
    } t_voice;

endpackage

>>> design/svm_seq.sv
`timescale 1ns / 1ps
// svm_seq: sequencer that steps the shared multiplier through one item
// depends on svm_pkg

module svm_seq
    import svm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_fire,
    input  logic     i_last,
    input  logic     i_stereo,
    input  logic     i_out_free,
    output logic     o_ready,
    output t_dp_ctrl o_ctrl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_fire) n_state = ST_VOICE_L;
            end
            ST_VOICE_L:   n_state = ST_VOICE_R;
            ST_VOICE_R:   n_state = ST_VOICE_ACC;
            ST_VOICE_ACC: n_state = i_last ? ST_MIX_L : ST_IDLE;
            ST_MIX_L:     n_state = ST_OUT_L;
            ST_OUT_L: begin
                if (i_out_free) n_state = i_stereo ? ST_OUT_R : ST_IDLE;
            end
            ST_OUT_R: begin
                if (i_out_free) n_state = ST_IDLE;
            end
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_state == ST_IDLE);
        o_ctrl  = '0;
        o_ctrl.mul_sel = MSEL_VOICE_L;
        case (r_state)
            ST_VOICE_L: begin
                o_ctrl.mul_sel = MSEL_VOICE_L;
                o_ctrl.prod_en = 1'b1;
            end
            ST_VOICE_R: begin
                o_ctrl.acc_l   = 1'b1;
                o_ctrl.mul_sel = MSEL_VOICE_R;
                o_ctrl.prod_en = 1'b1;
            end
            ST_VOICE_ACC: begin
                o_ctrl.acc_r = 1'b1;
            end
            ST_MIX_L: begin
                o_ctrl.mul_sel = MSEL_SUM_L;
                o_ctrl.prod_en = 1'b1;
            end
            ST_OUT_L: begin
                o_ctrl.mul_sel = MSEL_SUM_R;
                if (i_out_free) begin
                    o_ctrl.prod_en    = 1'b1;
                    o_ctrl.clear      = 1'b1;
                    o_ctrl.word_load  = 1'b1;
                    o_ctrl.word_right = 1'b0;
                    o_ctrl.word_last  = !i_stereo;
                    o_ctrl.wp_bump    = !i_stereo;
                end
            end
            ST_OUT_R: begin
                if (i_out_free) begin
                    o_ctrl.word_load  = 1'b1;
                    o_ctrl.word_right = 1'b1;
                    o_ctrl.word_last  = 1'b1;
                    o_ctrl.wp_bump    = 1'b1;
                end
            end
            default: begin
                o_ctrl.prod_en = 1'b0;
            end
        endcase
    end

endmodule

>>> design/svm_datapath.sv
`timescale 1ns / 1ps
// svm_datapath: shared signed multiplier, product register, mix sums and clip
// depends on svm_pkg; steered by svm_seq

module svm_datapath
    import svm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_ctrl    i_ctrl,
    input  t_voice      i_voice,
    input  logic [9:0]  i_master,
    input  logic        i_out_8bit,
    output logic [15:0] o_word
);

    logic signed [PROD_W-1:0] r_prod;
    logic [31:0]              r_left_sum;
    logic [31:0]              r_right_sum;

    logic [9:0]               w_vol;
    logic [7:0]               w_vol8;
    logic signed [31:0]       w_op_a;
    logic [9:0]               w_op_b;
    logic signed [42:0]       w_mul;
    logic [31:0]              w_term;
    logic signed [33:0]       w_mix;
    logic [15:0]              w_clip;

    always_comb begin
        w_vol  = (i_ctrl.mul_sel == MSEL_VOICE_R) ? i_voice.rvol : i_voice.lvol;
        w_vol8 = (w_vol > 10'd255) ? 8'd255 : w_vol[7:0];
        case (i_ctrl.mul_sel)
            MSEL_VOICE_L, MSEL_VOICE_R: begin
                if (i_voice.is_8bit) begin
                    w_op_a = {{24{i_voice.sample[7]}}, i_voice.sample[7:0]};
                    w_op_b = {2'b00, w_vol8[7:3], 3'b000};
                end else begin
                    w_op_a = {{16{i_voice.sample[15]}}, i_voice.sample};
                    w_op_b = w_vol;
                end
            end
            MSEL_SUM_L: begin
                w_op_a = r_left_sum;
                w_op_b = i_master;
            end
            MSEL_SUM_R: begin
                w_op_a = r_right_sum;
                w_op_b = i_master;
            end
            default: begin
                w_op_a = '0;
                w_op_b = '0;
            end
        endcase
        w_mul = w_op_a * $signed({1'b0, w_op_b});
    end

    // 8-bit voice terms carry no scaling shift
    assign w_term = i_voice.is_8bit ? r_prod[31:0] : r_prod[39:8];

    always_ff @(posedge i_clk) begin
        if (i_ctrl.prod_en) begin
            r_prod <= w_mul[PROD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_sum  <= '0;
            r_right_sum <= '0;
        end else if (i_ctrl.clear) begin
            r_left_sum  <= '0;
            r_right_sum <= '0;
        end else begin
            if (i_ctrl.acc_l && i_voice.active) r_left_sum <= r_left_sum + w_term;
            if (i_ctrl.acc_r && i_voice.active) r_right_sum <= r_right_sum + w_term;
        end
    end

    always_comb begin
        w_mix = r_prod[PROD_W-1:8];
        if (!w_mix[33] && (|w_mix[32:15])) begin
            w_clip = SAT_MAX;
        end else if (w_mix[33] && !(&w_mix[32:15])) begin
            w_clip = SAT_MIN;
        end else begin
            w_clip = w_mix[15:0];
        end
        o_word = i_out_8bit ? {8'h00, w_clip[15:8] ^ OFFSET_8} : w_clip;
    end

endmodule

>>> design/stereo_voice_mixer_unit.sv
`timescale 1ns / 1ps
// stereo_voice_mixer_unit: top level of the stereo voice mixer
// depends on svm_pkg, svm_seq and svm_datapath
//
// usage
//   s_axis carries one voice sample per item; tlast closes the output frame.
//   m_axis carries mixed words: left then right in stereo, left only in mono,
//   with the ring index beside each word and tlast on the frame's final word.
//   the cfg channel writes the four registers, always ready; the user must
//   write it only while no item is in progress; the unit does not enforce it.
// timing
//   one signed multiplier is shared: two products per voice, two per frame.
//   tready is low from accept until the sequencer is back in idle. a voice
//   item steps through VOICE_L, VOICE_R and VOICE_ACC; a frame-closing item
//   goes on to MIX_L, OUT_L (left word) and in stereo OUT_R (right word).
//   a stalled receiver holds the sequencer in its output step; the output
//   register keeps the last word while the next voice items are accepted.
// reset
//   sums and frame position clear, registers take their reset values.

module stereo_voice_mixer_unit
    import svm_pkg::*;
#(
    parameter int RING_INDEX_BITS = RING_INDEX_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [15:0] sample_value, [25:16] left_volume, [35:26] right_volume
    input  logic [39:0]            s_axis_tdata,
    // [0] voice_is_8bit, [1] voice_active
    input  logic [1:0]             s_axis_tuser,
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [15:0] out_data, [31:16] ring_index
    output logic [31:0]            m_axis_tdata,
    // [0] is_right
    output logic                   m_axis_tuser,
    output logic                   m_axis_tlast,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic [9:0]                 r_master;
    logic                       r_out_8bit;
    logic                       r_stereo;
    logic [4:0]                 r_ring_log2;
    logic [RING_INDEX_BITS-1:0] r_wp;
    t_voice                     r_voice;

    logic                       r_out_valid;
    logic [15:0]                r_out_data;
    logic [15:0]                r_out_index;
    logic                       r_out_right;
    logic                       r_out_last;

    t_dp_ctrl                   w_ctrl;
    logic                       w_ready;
    logic                       w_in_fire;
    logic                       w_out_free;
    logic [15:0]                w_word;
    logic [4:0]                 w_lg;
    logic [31:0]                w_idx;
    logic [15:0]                w_ring;

    assign w_in_fire     = s_axis_tvalid && w_ready;
    assign s_axis_tready = w_ready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_master    <= MASTER_VOLUME_RST;
            r_out_8bit  <= 1'b0;
            r_stereo    <= 1'b1;
            r_ring_log2 <= RING_SIZE_LOG2_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MASTER_VOLUME:  r_master    <= i_cfg_data[9:0];
                CFG_OUTPUT_8BIT:    r_out_8bit  <= i_cfg_data[0];
                CFG_OUTPUT_STEREO:  r_stereo    <= i_cfg_data[0];
                CFG_RING_SIZE_LOG2: r_ring_log2 <= i_cfg_data[4:0];
                default:            r_master    <= r_master;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_voice.sample  <= s_axis_tdata[15:0];
            r_voice.lvol    <= s_axis_tdata[25:16];
            r_voice.rvol    <= s_axis_tdata[35:26];
            r_voice.is_8bit <= s_axis_tuser[0];
            r_voice.active  <= s_axis_tuser[1];
            r_voice.last    <= s_axis_tlast;
        end
    end

    svm_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (w_in_fire),
        .i_last     (r_voice.last),
        .i_stereo   (r_stereo),
        .i_out_free (w_out_free),
        .o_ready    (w_ready),
        .o_ctrl     (w_ctrl)
    );

    svm_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_ctrl),
        .i_voice    (r_voice),
        .i_master   (r_master),
        .i_out_8bit (r_out_8bit),
        .o_word     (w_word)
    );

    // ring index, wrapped by the clamped ring size
    always_comb begin
        if (r_ring_log2 == 5'd0) begin
            w_lg = 5'd1;
        end else if (r_ring_log2 > 5'(RING_INDEX_BITS)) begin
            w_lg = 5'(RING_INDEX_BITS);
        end else begin
            w_lg = r_ring_log2;
        end
        w_idx = (32'(r_wp) << r_stereo) | 32'(w_ctrl.word_right);
        for (int b = 0; b < 16; b++) begin
            w_ring[b] = w_idx[b] && (5'(b) < w_lg);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
        end else if (w_ctrl.wp_bump) begin
            r_wp <= r_wp + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.word_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.word_load) begin
            r_out_data  <= w_word;
            r_out_index <= w_ring;
            r_out_right <= w_ctrl.word_right;
            r_out_last  <= w_ctrl.word_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_index, r_out_data};
    assign m_axis_tuser  = r_out_right;
    assign m_axis_tlast  = r_out_last;

endmodule

>>> design/svm_checker.sv
`timescale 1ns / 1ps
// svm_checker: port-level assertions for stereo_voice_mixer_unit, bound in below
// depends on the port list of stereo_voice_mixer_unit

module svm_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic        m_axis_tuser,
    input  logic        m_axis_tlast
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after an accepted item");

    a_right_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("right word not marked last of frame");

    a_right_index_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[16])
        else $error("right word at even ring index");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output item changed");

endmodule

bind stereo_voice_mixer_unit svm_checker u_svm_checker (.*);
